>>> rtl/cmrc_pkg.sv
`default_nettype none

package cmrc_pkg;

	// Field widths of one input word and one result word.
	localparam int unsigned MV_W    = 14;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COMP_W  = 18;
	localparam int unsigned CUR_W   = 32;
	localparam int unsigned DIV_W   = 16;
	localparam int unsigned GAIN_W  = 26;
	localparam int unsigned RATE_W  = 24;
	localparam int unsigned PHASE_W = 2;

	// Stream payload widths, padded to whole bytes.
	localparam int unsigned S_TDATA_W = 56;
	localparam int unsigned M_TDATA_W = 80;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = GAIN_W;
	localparam int unsigned CFG_PHASES = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DIV0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIV1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIV2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATE = 3'd6;

	localparam logic [DIV_W-1:0]  DIV_RESET  = 16'd6144;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 26'd1638400;
	localparam logic [RATE_W-1:0] RATE_RESET = 24'd100000;

	localparam logic signed [COMP_W-1:0] ZERO_DEFAULT_MV = 18'sd2500;

	// Milliseconds per second, applied to the current step in the slew test.
	localparam int unsigned     MS_PER_S_W = 10;
	localparam logic [MS_PER_S_W-1:0] MS_PER_S = 10'd1000;

	// Fixed point fraction bits of the divider ratio and of the gain.
	localparam int unsigned DIV_FRAC  = 12;
	localparam int unsigned GAIN_FRAC = 16;

	// Shared scaling multiplier: signed operand times unsigned ratio.
	localparam int unsigned MUL_A_W = COMP_W + 1;
	localparam int unsigned MUL_P_W = MUL_A_W + GAIN_W;
	localparam int unsigned MUL_R_W = MUL_P_W - DIV_FRAC;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_READ_FAIL = 2'd1,
		ST_BAD_PHASE = 2'd2,
		ST_CAL_FAIL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		Q_GOOD     = 2'd0,
		Q_DEGRADED = 2'd1,
		Q_INVALID  = 2'd2
	} quality_t;

	typedef enum logic [1:0] {
		KIND_MEASURE   = 2'd0,
		KIND_READ_FAIL = 2'd1,
		KIND_CAL       = 2'd2,
		KIND_BAD_PHASE = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_COMP,
		BS_CUR,
		BS_PREV,
		BS_RATE,
		BS_CMP,
		BS_CAL_ACC,
		BS_CAL_CHK,
		BS_CAL_DIV,
		BS_CAL_SCALE,
		BS_EMIT
	} back_state_t;

	typedef struct packed {
		logic [CFG_PHASES-1:0][DIV_W-1:0]  div;
		logic [CFG_PHASES-1:0][GAIN_W-1:0] gain;
		logic [RATE_W-1:0]                 rate;
	} cfg_t;

	typedef struct packed {
		kind_t               kind;
		logic [PHASE_W-1:0]  phase;
		logic [MV_W-1:0]     sample_mv;
		logic                sample_ok;
		logic [TIME_W-1:0]   time_ms;
	} item_t;

	typedef struct packed {
		status_t             status;
		logic [PHASE_W-1:0]  phase;
		logic [COMP_W-1:0]   comp_mv;
		logic [CUR_W-1:0]    current_ma;
		quality_t            quality;
		logic                is_cal;
		logic [COMP_W-1:0]   zero_mv;
	} res_t;

	// Handshake between the front stage and the item queue.
	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

endpackage

`default_nettype wire

>>> rtl/cmrc_front.sv
`default_nettype none

module cmrc_front #(
	parameter int unsigned NUM_PHASES = 3
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [cmrc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	input  wire logic                              s_axis_tuser,
	input  wire logic                              q_full,
	output cmrc_pkg::qctl_t                        qctl,
	output cmrc_pkg::item_t                        q_item
);
	import cmrc_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_in;
	logic  push;
	logic  take;

	// Unpack the word and sort it into one of four kinds.
	always_comb begin
		item_in.phase     = s_axis_tdata[1:0];
		item_in.sample_mv = s_axis_tdata[15:2];
		item_in.sample_ok = s_axis_tdata[16];
		item_in.time_ms   = s_axis_tdata[48:17];
		if (32'(item_in.phase) >= NUM_PHASES) begin
			item_in.kind = KIND_BAD_PHASE;
		end else if (s_axis_tuser) begin
			item_in.kind = KIND_CAL;
		end else if (!item_in.sample_ok) begin
			item_in.kind = KIND_READ_FAIL;
		end else begin
			item_in.kind = KIND_MEASURE;
		end
	end

	assign push          = valid_s1 && !q_full;
	assign s_axis_tready = !valid_s1 || !q_full;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

	assign qctl.push = push;
	assign qctl.full = q_full;
	assign q_item    = item_s1;

endmodule

`default_nettype wire

>>> rtl/cmrc_queue.sv
`default_nettype none

module cmrc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cmrc_pkg::qctl_t qctl,
	input  wire cmrc_pkg::item_t wr_item,
	output logic                 full,
	output logic                 not_empty,
	output cmrc_pkg::item_t      rd_item,
	input  wire logic            pop
);
	import cmrc_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qctl.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({qctl.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (qctl.push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.push |-> !full)
		else $error("word pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("word popped from an empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> rtl/cmrc_div.sv
`default_nettype none

module cmrc_div #(
	parameter int unsigned NUM_W = 19,
	parameter int unsigned DEN_W = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);
	localparam int unsigned STEP_W = $clog2(NUM_W + 1);

	logic [DEN_W:0]    rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    rem_sh;
	logic              fits;

	// Restoring division, one quotient bit per cycle, most significant first.
	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign fits   = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

>>> rtl/cmrc_back.sv
`default_nettype none

module cmrc_back #(
	parameter int unsigned NUM_PHASES  = 3,
	parameter int unsigned CAL_SAMPLES = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cmrc_pkg::cfg_t  cfg,
	input  wire logic            q_valid,
	input  wire cmrc_pkg::item_t q_item,
	output logic                 q_pop,
	output logic                 m_valid,
	input  wire logic            m_ready,
	output cmrc_pkg::res_t       m_res
);
	import cmrc_pkg::*;

	localparam int unsigned PH_W  = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
	localparam int unsigned CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam int unsigned SUM_W = MV_W + $clog2(CAL_SAMPLES);
	localparam int unsigned HALF  = CAL_SAMPLES / 2;
	localparam int unsigned LHS_W = CUR_W + 1 + MS_PER_S_W;
	localparam int unsigned RHS_W = RATE_W + TIME_W;

	back_state_t state_q, state_d;

	item_t item_q;
	res_t  res_q;
	res_t  out_q;
	logic  out_valid_q;
	logic  out_free;

	logic signed [COMP_W-1:0] zero_q  [NUM_PHASES];
	logic signed [COMP_W-1:0] lcomp_q [NUM_PHASES];
	logic [TIME_W-1:0]        ltime_q [NUM_PHASES];

	logic signed [SUM_W-1:0] cal_sum_q;
	logic [CNT_W-1:0]        cal_good_q;
	logic [CNT_W-1:0]        cal_att_q;
	logic [PHASE_W-1:0]      cal_ph_q;

	logic signed [COMP_W-1:0] comp_q;
	logic signed [CUR_W-1:0]  cur_q;
	logic signed [CUR_W-1:0]  prev_q;
	logic [LHS_W-1:0]         lhs_q;
	logic [RHS_W-1:0]         rhs_q;
	logic                     skip_q;

	logic [PH_W-1:0]          pidx;
	logic [PH_W-1:0]          qidx;
	logic signed [COMP_W-1:0] zero_cur;
	logic signed [COMP_W-1:0] lcomp_cur;
	logic [TIME_W-1:0]        ltime_cur;
	logic [TIME_W-1:0]        dt;
	logic signed [CUR_W:0]    dcur;
	logic [CUR_W:0]           dmag;

	logic signed [MUL_A_W-1:0] mul_a;
	logic [GAIN_W-1:0]         mul_k;
	logic                      mul_gain;
	logic                      mul_neg;
	logic [MUL_A_W-1:0]        mul_mag;
	logic [MUL_P_W-1:0]        mul_p;
	logic [MUL_R_W-1:0]        mul_sh;
	logic signed [MUL_R_W:0]   mul_res;

	logic                    cal_restart;
	logic                    div_start;
	logic                    div_done;
	logic [SUM_W-1:0]        div_num;
	logic [SUM_W-1:0]        div_quo;
	logic signed [MUL_A_W-1:0] avg;

	assign pidx      = item_q.phase[PH_W-1:0];
	assign qidx      = q_item.phase[PH_W-1:0];
	assign zero_cur  = zero_q[pidx];
	assign lcomp_cur = lcomp_q[pidx];
	assign ltime_cur = ltime_q[pidx];
	assign out_free  = !out_valid_q || m_ready;

	// Shared scaling multiplier: magnitude times ratio, truncated toward zero.
	always_comb begin
		mul_a    = '0;
		mul_k    = '0;
		mul_gain = 1'b0;
		unique case (state_q)
			BS_COMP: begin
				mul_a = MUL_A_W'($signed(item_q.sample_mv));
				mul_k = GAIN_W'(cfg.div[item_q.phase]);
			end
			BS_CUR: begin
				mul_a    = MUL_A_W'(comp_q) - MUL_A_W'(zero_cur);
				mul_k    = cfg.gain[item_q.phase];
				mul_gain = 1'b1;
			end
			BS_PREV: begin
				mul_a    = MUL_A_W'(lcomp_cur) - MUL_A_W'(zero_cur);
				mul_k    = cfg.gain[item_q.phase];
				mul_gain = 1'b1;
			end
			BS_CAL_SCALE: begin
				mul_a = avg;
				mul_k = GAIN_W'(cfg.div[item_q.phase]);
			end
			default: begin
				mul_a = '0;
			end
		endcase
		mul_neg = mul_a[MUL_A_W-1];
		mul_mag = mul_neg ? -mul_a : mul_a;
		mul_p   = MUL_P_W'(mul_mag) * MUL_P_W'(mul_k);
		mul_sh  = mul_gain ? MUL_R_W'(mul_p >> GAIN_FRAC) : MUL_R_W'(mul_p >> DIV_FRAC);
		mul_res = mul_neg ? -$signed({1'b0, mul_sh}) : $signed({1'b0, mul_sh});
	end

	assign dt   = item_q.time_ms - ltime_cur;
	assign dcur = (CUR_W + 1)'(cur_q) - (CUR_W + 1)'(prev_q);
	assign dmag = dcur[CUR_W] ? -dcur : dcur;

	assign cal_restart = (cal_att_q != '0) && (cal_ph_q != item_q.phase);
	assign div_num     = cal_sum_q[SUM_W-1] ? -cal_sum_q : cal_sum_q;
	assign avg         = cal_sum_q[SUM_W-1] ? -MUL_A_W'(div_quo) : MUL_A_W'(div_quo);

	cmrc_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (cal_good_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			BS_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_item.kind)
						KIND_MEASURE: state_d = BS_COMP;
						KIND_CAL:     state_d = BS_CAL_ACC;
						default:      state_d = BS_EMIT;
					endcase
				end
			end
			BS_COMP:    state_d = BS_CUR;
			BS_CUR:     state_d = BS_PREV;
			BS_PREV:    state_d = BS_RATE;
			BS_RATE:    state_d = BS_CMP;
			BS_CMP:     state_d = BS_EMIT;
			BS_CAL_ACC: state_d = BS_CAL_CHK;
			BS_CAL_CHK: begin
				if (cal_att_q < CNT_W'(CAL_SAMPLES)) begin
					state_d = BS_IDLE;
				end else if (cal_good_q < CNT_W'(HALF)) begin
					state_d = BS_EMIT;
				end else begin
					div_start = 1'b1;
					state_d   = BS_CAL_DIV;
				end
			end
			BS_CAL_DIV: begin
				if (div_done) begin
					state_d = BS_CAL_SCALE;
				end
			end
			BS_CAL_SCALE: state_d = BS_EMIT;
			BS_EMIT: begin
				if (out_free) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// Per-phase history and the calibration run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PHASES; i++) begin
				zero_q[i]  <= ZERO_DEFAULT_MV;
				lcomp_q[i] <= '0;
				ltime_q[i] <= '0;
			end
			cal_sum_q  <= '0;
			cal_good_q <= '0;
			cal_att_q  <= '0;
			cal_ph_q   <= '0;
		end else begin
			unique case (state_q)
				BS_CMP: begin
					lcomp_q[pidx] <= comp_q;
					ltime_q[pidx] <= item_q.time_ms;
				end
				BS_CAL_ACC: begin
					cal_ph_q  <= item_q.phase;
					cal_att_q <= (cal_restart ? '0 : cal_att_q) + 1'b1;
					cal_good_q <= (cal_restart ? '0 : cal_good_q) + CNT_W'(item_q.sample_ok);
					cal_sum_q  <= (cal_restart ? '0 : cal_sum_q)
						+ (item_q.sample_ok ? SUM_W'($signed(item_q.sample_mv)) : '0);
				end
				BS_CAL_CHK: begin
					if (cal_att_q >= CNT_W'(CAL_SAMPLES) && cal_good_q < CNT_W'(HALF)) begin
						cal_sum_q  <= '0;
						cal_good_q <= '0;
						cal_att_q  <= '0;
					end
				end
				BS_CAL_SCALE: begin
					zero_q[pidx] <= mul_res[COMP_W-1:0];
					cal_sum_q    <= '0;
					cal_good_q   <= '0;
					cal_att_q    <= '0;
				end
				default: begin
					cal_ph_q <= cal_ph_q;
				end
			endcase
		end
	end

	// Working registers and the pending result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BS_IDLE: begin
				if (q_valid) begin
					item_q             <= q_item;
					res_q.phase        <= q_item.phase;
					res_q.comp_mv      <= '0;
					res_q.current_ma   <= '0;
					res_q.quality      <= Q_INVALID;
					res_q.is_cal       <= 1'b0;
					if (q_item.kind == KIND_BAD_PHASE) begin
						res_q.status  <= ST_BAD_PHASE;
						res_q.zero_mv <= '0;
					end else begin
						res_q.status  <= ST_READ_FAIL;
						res_q.zero_mv <= zero_q[qidx];
					end
				end
			end
			BS_COMP: comp_q <= mul_res[COMP_W-1:0];
			BS_CUR:  cur_q  <= mul_res[CUR_W-1:0];
			BS_PREV: prev_q <= mul_res[CUR_W-1:0];
			BS_RATE: begin
				lhs_q  <= LHS_W'(dmag) * LHS_W'(MS_PER_S);
				rhs_q  <= RHS_W'(cfg.rate) * RHS_W'(dt);
				skip_q <= (ltime_cur == '0) || (dt == '0);
			end
			BS_CMP: begin
				res_q.status     <= ST_OK;
				res_q.comp_mv    <= comp_q;
				res_q.current_ma <= cur_q;
				res_q.quality    <= (!skip_q && (RHS_W'(lhs_q) > rhs_q)) ? Q_DEGRADED : Q_GOOD;
				res_q.is_cal     <= 1'b0;
				res_q.zero_mv    <= zero_cur;
			end
			BS_CAL_CHK: begin
				res_q.status     <= ST_CAL_FAIL;
				res_q.comp_mv    <= '0;
				res_q.current_ma <= '0;
				res_q.quality    <= Q_INVALID;
				res_q.is_cal     <= 1'b1;
				res_q.zero_mv    <= zero_cur;
			end
			BS_CAL_SCALE: begin
				res_q.status  <= ST_OK;
				res_q.quality <= Q_GOOD;
				res_q.zero_mv <= mul_res[COMP_W-1:0];
			end
			default: begin
				skip_q <= skip_q;
			end
		endcase
	end

	// Output register: a finished result waits here while the next word is worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BS_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BS_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	assign m_valid = out_valid_q;
	assign m_res   = out_q;

	a_good_le_att: assert property (@(posedge clk) disable iff (!arst_n)
		cal_good_q <= cal_att_q)
		else $error("more good calibration samples than attempts");

	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BS_IDLE |-> cal_att_q < CNT_W'(CAL_SAMPLES))
		else $error("full calibration run left open");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == BS_CAL_DIV)
		else $error("divider finished outside of the wait state");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != BS_IDLE)
		else $error("popped word was not taken up");

endmodule

`default_nettype wire

>>> rtl/current_monitor_rate_check_unit.sv
`default_nettype none

// Channel     Direction  tdata fields, lowest bit first                         tuser
// s_axis      in         phase 2, sample_mv 14, sample_ok 1, time_ms 32 (56b)     command
// m_axis      out        status 2, result_phase 2, compensated_mv 18,             is_calibration
//                        current_ma 32, quality 2, zero_offset_out 18 (80b)
// cfg         in         cfg_we, cfg_index 3, cfg_wdata 26; write only
//
// A measure word passes the input stage and the queue, then the back steps COMP,
// CUR and PREV on the shared 19x26 scaling multiplier, RATE and CMP for the slew
// compare, and EMIT. The word that closes a calibration run also waits on the
// bit-serial divider that forms the average (one quotient bit per cycle); other
// calibration words pass only the CAL_ACC and CAL_CHK steps.
// Reset clears the control state and loads the register defaults and the default
// zero offsets; no clearing pass follows. Until the queue fills, the front accepts
// words into the two-entry queue while the back is busy or its result is not yet taken.
module current_monitor_rate_check_unit #(
	parameter int unsigned NUM_PHASES  = 3,
	parameter int unsigned CAL_SAMPLES = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	// Input words. tdata: phase, sample_mv, sample_ok, time_ms. tuser: command.
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [cmrc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	input  wire logic                                s_axis_tuser,

	// Result words. tdata: status, result_phase, compensated_mv, current_ma,
	// quality, zero_offset_out. tuser: is_calibration.
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [cmrc_pkg::M_TDATA_W-1:0]           m_axis_tdata,
	output logic                                     m_axis_tuser,

	// Configuration writes.
	input  wire logic                                cfg_we,
	input  wire logic [cmrc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cmrc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import cmrc_pkg::*;

	cfg_t  cfg_q;
	qctl_t qctl;
	item_t front_item;
	item_t queue_item;
	logic  q_full;
	logic  q_not_empty;
	logic  q_pop;
	res_t  res;

	// Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_PHASES; i++) begin
				cfg_q.div[i]  <= DIV_RESET;
				cfg_q.gain[i] <= GAIN_RESET;
			end
			cfg_q.rate <= RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIV0:  cfg_q.div[0]  <= cfg_wdata[DIV_W-1:0];
				REG_DIV1:  cfg_q.div[1]  <= cfg_wdata[DIV_W-1:0];
				REG_DIV2:  cfg_q.div[2]  <= cfg_wdata[DIV_W-1:0];
				REG_GAIN0: cfg_q.gain[0] <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN1: cfg_q.gain[1] <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN2: cfg_q.gain[2] <= cfg_wdata[GAIN_W-1:0];
				REG_RATE:  cfg_q.rate    <= cfg_wdata[RATE_W-1:0];
				default:   cfg_q.rate    <= cfg_q.rate;
			endcase
		end
	end

	// Front: takes words and sorts them into measure, read failure, calibration
	// or bad phase.
	cmrc_front #(
		.NUM_PHASES (NUM_PHASES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.qctl          (qctl),
		.q_item        (front_item)
	);

	// Queue between the two halves so that each can stall on its own.
	cmrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.qctl      (qctl),
		.wr_item   (front_item),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rd_item   (queue_item),
		.pop       (q_pop)
	);

	// Back: scaling, slew check, calibration and the result register.
	cmrc_back #(
		.NUM_PHASES  (NUM_PHASES),
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_not_empty),
		.q_item  (queue_item),
		.q_pop   (q_pop),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_res   (res)
	);

	assign m_axis_tdata = {6'b0, res.zero_mv, res.quality, res.current_ma,
		res.comp_mv, res.phase, res.status};
	assign m_axis_tuser = res.is_cal;

endmodule

`default_nettype wire
